### rtl/core/yaz0_stream_decompressor_top_macros.svh
// Assertion macros for the Yaz0 stream decompressor.
// Used by the checker module only.
`ifndef YAZ0_STREAM_DECOMPRESSOR_TOP_MACROS_SVH
`define YAZ0_STREAM_DECOMPRESSOR_TOP_MACROS_SVH
// An implication checked at every clock edge outside reset.
`define YZ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// An implication whose consequent is checked in the cycle after the antecedent.
`define YZ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/core/yaz0_pkg.sv
// Package for the Yaz0 stream decompressor: constants, status codes and the
// command and status structs between the controller and the datapath.
package yaz0_pkg;
   localparam int HistAw = 12;
   localparam int BytesPerWord = 8;
   localparam logic [31:0] MagicWord = 32'h59617A30;

   localparam logic [1:0] StOk        = 2'd0;
   localparam logic [1:0] StBadHeader = 2'd1;
   localparam logic [1:0] StTruncated = 2'd2;
   localparam logic [1:0] StBadDist   = 2'd3;

   typedef struct packed {
      logic       clear;      // new stream: clear counters
      logic       hdr_byte;   // shift a size byte in
      logic       put_lit;    // write the input byte as a literal
      logic       put_copy;   // write the byte read back from history
      logic       issue_rd;   // start a history read at the copy source
      logic       flush;      // send the packed word
      logic       load_dist;  // latch distance from the code bytes
   } cmd_type;

   typedef struct packed {
      logic [31:0] out_pos;
      logic [31:0] size_total;
      logic        pack_full;
      logic        pack_empty;
      logic        out_busy;
   } stat_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        run_last;
      logic        stream_done;
      logic [1:0]  status;
      logic [31:0] total_size;
   } rsp_type;
endpackage

### rtl/core/yaz0_if.sv
// Valid and ready channel interfaces for the Yaz0 decompressor.
// Depends on yaz0_pkg for the result word type.
interface yaz0_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_start;
   logic       stream_last;
   modport source (output valid, in_byte, stream_start, stream_last, input ready);
   modport sink (input valid, in_byte, stream_start, stream_last, output ready);
endinterface

interface yaz0_rsp_if;
   logic                 valid;
   logic                 ready;
   yaz0_pkg::rsp_type    payload;
   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

### rtl/core/yaz0_datapath.sv
// Datapath of the Yaz0 decompressor: history memory, counters, word packer
// and output register. Depends on yaz0_pkg.
module yaz0_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  yaz0_pkg::cmd_type    cmd,
   input  logic [7:0]           in_byte,
   input  logic [11:0]          dist_val,
   input  logic                 send_last,
   input  logic                 send_done,
   input  logic [1:0]           send_status,
   output yaz0_pkg::stat_type   stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output yaz0_pkg::rsp_type    rsp_payload
);
   logic [7:0]  hist_mem [0:(1 << yaz0_pkg::HistAw) - 1];
   logic [7:0]  rd_data_ff;
   logic [31:0] out_pos_ff, out_pos_in;
   logic [31:0] size_ff, size_in;
   logic [11:0] dist_ff;
   logic [63:0] pack_ff, pack_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        ovalid_ff;
   yaz0_pkg::rsp_type opay_ff;
   logic [7:0]  wr_byte;
   logic        wr_en;
   logic [31:0] rd_addr;

   assign wr_en = cmd.put_lit | cmd.put_copy;
   assign wr_byte = cmd.put_lit ? in_byte : rd_data_ff;
   assign rd_addr = out_pos_ff - {20'd0, dist_ff} - 32'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[out_pos_ff[yaz0_pkg::HistAw-1:0]] <= wr_byte;
      end
      if (cmd.issue_rd) begin
         rd_data_ff <= hist_mem[rd_addr[yaz0_pkg::HistAw-1:0]];
      end
      if (cmd.load_dist) begin
         dist_ff <= dist_val;
      end
   end

   always_comb begin
      out_pos_in = out_pos_ff;
      size_in = size_ff;
      pack_in = pack_ff;
      cnt_in = cnt_ff;
      if (cmd.flush) begin
         pack_in = '0;
         cnt_in = '0;
      end
      if (cmd.clear) begin
         out_pos_in = '0;
         size_in = '0;
         pack_in = '0;
         cnt_in = '0;
      end
      if (cmd.hdr_byte) begin
         size_in = {size_ff[23:0], in_byte};
      end
      if (wr_en) begin
         out_pos_in = out_pos_ff + 32'd1;
         pack_in = pack_ff | ({56'd0, wr_byte} << {cnt_ff[2:0], 3'b000});
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_pos_ff <= '0;
         size_ff <= '0;
         pack_ff <= '0;
         cnt_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         out_pos_ff <= out_pos_in;
         size_ff <= size_in;
         pack_ff <= pack_in;
         cnt_ff <= cnt_in;
         if (cmd.flush) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flush) begin
         opay_ff.data <= pack_ff;
         opay_ff.count <= cnt_ff;
         opay_ff.run_last <= send_last;
         opay_ff.stream_done <= send_done;
         opay_ff.status <= send_status;
         opay_ff.total_size <= size_ff;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_payload = opay_ff;
   assign stat.out_pos = out_pos_ff;
   assign stat.size_total = size_ff;
   assign stat.pack_full = (cnt_ff == 4'(yaz0_pkg::BytesPerWord));
   assign stat.pack_empty = (cnt_ff == 4'd0);
   assign stat.out_busy = ovalid_ff & ~rsp_ready;
endmodule

### rtl/core/yaz0_ctrl.sv
// Controller of the Yaz0 decompressor: header, flag and token parsing and
// the back-reference copy sequencer. Depends on yaz0_pkg.
module yaz0_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           in_byte,
   input  logic                 stream_start,
   input  logic                 stream_last,
   input  yaz0_pkg::stat_type   stat,
   output yaz0_pkg::cmd_type    cmd,
   output logic [11:0]          dist_val,
   output logic                 send_last,
   output logic                 send_done,
   output logic [1:0]           send_status
);
   localparam logic [2:0] SIdle = 3'd0;
   localparam logic [2:0] SRead = 3'd1;
   localparam logic [2:0] SWrite = 3'd2;
   localparam logic [2:0] SFinal = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic [7:0]  flags_ff, flags_in;
   logic [3:0]  bits_ff, bits_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  code1_ff, code1_in;
   logic [7:0]  code2_ff, code2_in;
   logic [1:0]  err_ff, err_in;
   logic        over_ff, over_in;
   logic [8:0]  len_ff, len_in;
   logic        last_ff, last_in;
   logic        ended_ff, ended_in;
   logic        sent_ff, sent_in;
   logic        hold;
   logic [31:0] dec_sz;
   logic [11:0] dist_now;

   // The output register must be free before any word can be flushed.
   assign hold = stat.out_busy;
   assign req_ready = (state_ff == SIdle) & ~hold;
   assign dist_now = {code1_ff[3:0], in_byte};
   assign send_status = err_in;

   always_comb begin
      logic accept;
      logic ended;
      logic more;
      logic [31:0] pos;
      accept = req_valid & req_ready;
      state_in = state_ff;
      hpos_in = hpos_ff;
      flags_in = flags_ff;
      bits_in = bits_ff;
      phase_in = phase_ff;
      code1_in = code1_ff;
      code2_in = code2_ff;
      err_in = err_ff;
      over_in = over_ff;
      len_in = len_ff;
      last_in = last_ff;
      ended_in = ended_ff;
      sent_in = sent_ff;
      cmd = '0;
      dist_val = dist_now;
      send_last = 1'b0;
      send_done = 1'b0;
      ended = 1'b0;
      more = 1'b0;
      dec_sz = stat.size_total;
      pos = stat.out_pos;
      unique case (state_ff)
         SIdle: begin
            if (accept) begin
               if (stream_start) begin
                  cmd.clear = 1'b1;
                  hpos_in = '0;
                  flags_in = '0;
                  bits_in = '0;
                  phase_in = '0;
                  code1_in = '0;
                  code2_in = '0;
                  err_in = yaz0_pkg::StOk;
                  over_in = 1'b0;
                  dec_sz = '0;
                  pos = '0;
               end
               sent_in = 1'b0;
               last_in = stream_last;
               if (!(over_ff && !stream_start)) begin
                  if (hpos_in < 5'd16) begin
                     if (hpos_in < 5'd4) begin
                        if (in_byte != yaz0_pkg::MagicWord[8*(3-hpos_in[1:0]) +: 8]) begin
                           err_in = yaz0_pkg::StBadHeader;
                           ended = 1'b1;
                        end
                     end else if (hpos_in < 5'd8) begin
                        cmd.hdr_byte = 1'b1;
                        dec_sz = {dec_sz[23:0], in_byte};
                     end
                     hpos_in = hpos_in + 5'd1;
                     if (!ended) begin
                        if (hpos_in == 5'd16) begin
                           if (dec_sz == 32'd0) begin
                              ended = 1'b1;
                           end else if (stream_last) begin
                              err_in = yaz0_pkg::StTruncated;
                              ended = 1'b1;
                           end
                        end else if (stream_last) begin
                           err_in = yaz0_pkg::StBadHeader;
                           ended = 1'b1;
                        end
                     end
                  end else if (bits_ff == 4'd0) begin
                     flags_in = in_byte;
                     bits_in = 4'd8;
                  end else if (phase_ff == 2'd0) begin
                     if (flags_ff[7]) begin
                        cmd.put_lit = 1'b1;
                        pos = pos + 32'd1;
                        flags_in = {flags_ff[6:0], 1'b0};
                        bits_in = bits_ff - 4'd1;
                     end else begin
                        code1_in = in_byte;
                        phase_in = 2'd1;
                     end
                  end else if (phase_ff == 2'd1) begin
                     code2_in = in_byte;
                     if ({20'd0, dist_now} >= pos) begin
                        err_in = yaz0_pkg::StBadDist;
                        ended = 1'b1;
                     end else if (code1_ff[7:4] != 4'd0) begin
                        cmd.load_dist = 1'b1;
                        len_in = {5'd0, code1_ff[7:4]} + 9'd2;
                        more = 1'b1;
                        flags_in = {flags_ff[6:0], 1'b0};
                        bits_in = bits_ff - 4'd1;
                        phase_in = 2'd0;
                     end else begin
                        phase_in = 2'd2;
                     end
                  end else begin
                     cmd.load_dist = 1'b1;
                     dist_val = {code1_ff[3:0], code2_ff};
                     len_in = {1'b0, in_byte} + 9'h12;
                     more = 1'b1;
                     flags_in = {flags_ff[6:0], 1'b0};
                     bits_in = bits_ff - 4'd1;
                     phase_in = 2'd0;
                  end
                  if (!ended && hpos_in >= 5'd16 && !more) begin
                     if (pos >= dec_sz) begin
                        ended = 1'b1;
                     end else if (stream_last) begin
                        err_in = yaz0_pkg::StTruncated;
                        ended = 1'b1;
                     end
                  end
                  ended_in = ended;
                  if (more) begin
                     state_in = SRead;
                  end else if (ended || cmd.put_lit) begin
                     state_in = SFinal;
                  end
                  if (ended) begin
                     over_in = 1'b1;
                  end
               end
            end
         end
         SRead: begin
            // A copy ends early once the decoded size is reached.
            if (len_ff == 9'd0 || pos >= dec_sz) begin
               if (pos >= dec_sz) begin
                  ended_in = 1'b1;
                  over_in = 1'b1;
               end else if (last_ff) begin
                  err_in = yaz0_pkg::StTruncated;
                  ended_in = 1'b1;
                  over_in = 1'b1;
               end
               state_in = SFinal;
            end else if (stat.pack_full) begin
               if (!hold) begin
                  cmd.flush = 1'b1;
                  sent_in = 1'b1;
               end
            end else begin
               cmd.issue_rd = 1'b1;
               state_in = SWrite;
            end
         end
         SWrite: begin
            cmd.put_copy = 1'b1;
            len_in = len_ff - 9'd1;
            state_in = SRead;
         end
         default: begin
            // Send the remaining word, full or not, as the last of the step, or
            // an empty one when the stream ends and no word was sent in this step.
            if (!hold) begin
               if (!stat.pack_empty) begin
                  cmd.flush = 1'b1;
                  send_last = 1'b1;
                  send_done = ended_ff;
               end else if (ended_ff && !sent_ff) begin
                  cmd.flush = 1'b1;
                  send_last = 1'b1;
                  send_done = 1'b1;
               end
               state_in = SIdle;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         hpos_ff <= '0;
         flags_ff <= '0;
         bits_ff <= '0;
         phase_ff <= '0;
         code1_ff <= '0;
         code2_ff <= '0;
         err_ff <= yaz0_pkg::StOk;
         over_ff <= 1'b0;
         len_ff <= '0;
         last_ff <= 1'b0;
         ended_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hpos_ff <= hpos_in;
         flags_ff <= flags_in;
         bits_ff <= bits_in;
         phase_ff <= phase_in;
         code1_ff <= code1_in;
         code2_ff <= code2_in;
         err_ff <= err_in;
         over_ff <= over_in;
         len_ff <= len_in;
         last_ff <= last_in;
         ended_ff <= ended_in;
         sent_ff <= sent_in;
      end
   end
endmodule

### rtl/core/yaz0_stream_decompressor_top.sv
// Yaz0 stream decompressor. Header, flag and code bytes are each taken by a
// plain accept; a literal is accepted, then its word is flushed. A back-reference
// is accepted, then each byte takes a read and a write through the single-port
// history memory, then come the end check and the last flush, with an extra
// flush for each full 8-byte word sent before the last. The next byte is taken once
// the last word of the previous one is in a free output register.
// Reset (synchronous, active high) clears the parser; history is not cleared.
module yaz0_stream_decompressor_top (
   input logic clock,
   input logic reset,
   yaz0_req_if.sink   req,
   yaz0_rsp_if.source rsp
);
   yaz0_pkg::cmd_type  cmd;
   yaz0_pkg::stat_type stat;
   logic [11:0]        dist_val;
   logic               send_last;
   logic               send_done;
   logic [1:0]         send_status;

   yaz0_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .in_byte(req.in_byte), .stream_start(req.stream_start),
      .stream_last(req.stream_last),
      .stat(stat), .cmd(cmd), .dist_val(dist_val),
      .send_last(send_last), .send_done(send_done), .send_status(send_status)
   );

   yaz0_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_byte(req.in_byte),
      .dist_val(dist_val), .send_last(send_last), .send_done(send_done),
      .send_status(send_status), .stat(stat),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
   );
endmodule

### rtl/core/yaz0_checker.sv
// Port checker for the Yaz0 decompressor, bound to the top level.
// Depends on yaz0_pkg and the macro header.
`include "yaz0_stream_decompressor_top_macros.svh"
module yaz0_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input yaz0_pkg::rsp_type  rsp_payload
);
   `YZ_ASSERT_IMPL(a_count_range, rsp_valid, rsp_payload.count <= 4'd8)
   `YZ_ASSERT_IMPL(a_done_is_last, rsp_valid && rsp_payload.stream_done, rsp_payload.run_last)
   `YZ_ASSERT_IMPL(a_mid_full, rsp_valid && !rsp_payload.run_last, rsp_payload.count == 4'd8)
   `YZ_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
endmodule

bind yaz0_stream_decompressor_top yaz0_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
